// File: rtl/isip_pkg.sv
// ============================================================================
// isip_pkg
// Shared types, widths and codes of the interval set with insert and pick.
// ============================================================================
package isip_pkg;

  // Table depth and the widths that follow from it.
  localparam int unsigned MAX_RANGES = 16;
  localparam int unsigned IDX_W      = $clog2(MAX_RANGES);
  localparam int unsigned CNT_W      = $clog2(MAX_RANGES + 1);

  // Field widths.
  localparam int unsigned ACT_W   = 2;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned STS_W   = 2;
  localparam int unsigned TOTAL_W = 37;
  localparam int unsigned USED_W  = 5;
  localparam int unsigned SIZE_W  = VAL_W + 1;

  // Stream word widths, padded to whole bytes.
  localparam int unsigned IN_BITS  = ACT_W + 3 * VAL_W;
  localparam int unsigned IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_BITS = VAL_W + STS_W + TOTAL_W + USED_W;
  localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  // Request codes.
  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_PICK   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

  // Result status codes.
  localparam logic [STS_W-1:0] STS_OK    = 2'd0;
  localparam logic [STS_W-1:0] STS_FULL  = 2'd1;
  localparam logic [STS_W-1:0] STS_ORDER = 2'd2;
  localparam logic [STS_W-1:0] STS_RANGE = 2'd3;

  // One stored range, first value in the low half.
  typedef struct packed {
    logic [VAL_W-1:0] last;
    logic [VAL_W-1:0] first;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // Number of values in an inclusive range.
  function automatic logic [SIZE_W-1:0] range_size(input entry_t ent);
    range_size = {1'b0, ent.last - ent.first} + SIZE_W'(1);
  endfunction

endpackage

// File: rtl/interval_set_insert_and_pick_top.sv
// ============================================================================
// interval_set_insert_and_pick_top
// Sorted table of inclusive 32-bit ranges with insert, pick by position and
// clear. The ranges live in one RAM that is walked one entry per cycle.
// ============================================================================
// Clear, unused codes, start-above-end and a pick on an empty table go
// straight to the response; an insert into an empty table goes straight
// to the shift step. A pick, or an insert, scans the stored entries; an
// insert that opens a position below the top then shifts entries up.
// Throughput: one request at a time, one entry read per cycle. Reset empties
// the table at once, with no clearing pass.
// ============================================================================
module interval_set_insert_and_pick_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // action[1:0], range_start[33:2], range_end[65:34], pick_index[97:66]
  input  logic [isip_pkg::IN_W-1:0] s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // picked_value[31:0], status[33:32], total_count[70:34],
  // entries_used[75:71]
  output logic [isip_pkg::OUT_W-1:0] m_axis_tdata
);

  import isip_pkg::*;

  // Sequencer states.
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_RESP  = 2'd3;

  logic [1:0]         state_q, state_d;

  // Table bookkeeping.
  logic [CNT_W-1:0]   used_q, used_d;
  logic [TOTAL_W-1:0] total_q, total_d;

  // Request fields held while the request is in work.
  logic [ACT_W-1:0]   act_q, act_d;
  logic [VAL_W-1:0]   start_q, start_d;
  logic [VAL_W-1:0]   end_q, end_d;
  logic [VAL_W-1:0]   rem_q, rem_d;

  // Table walk: rd_idx is the next entry to read, chk_idx the one whose
  // data comes back from the RAM in this cycle.
  logic [CNT_W-1:0]   rd_idx_q, rd_idx_d;
  logic               chk_q, chk_d;
  logic [CNT_W-1:0]   chk_idx_q, chk_idx_d;

  // Insertion point and shifting.
  logic [CNT_W-1:0]   pos_q, pos_d;
  logic               pos_found_q, pos_found_d;
  logic [CNT_W-1:0]   shr_idx_q, shr_idx_d;
  logic               pend_q, pend_d;
  logic [CNT_W-1:0]   pend_addr_q, pend_addr_d;

  // Result of the request in work.
  logic [VAL_W-1:0]   res_val_q, res_val_d;
  logic [STS_W-1:0]   res_sts_q, res_sts_d;

  // Output register.
  logic               out_vld_q, out_vld_d;
  logic [VAL_W-1:0]   out_val_q, out_val_d;
  logic [STS_W-1:0]   out_sts_q, out_sts_d;
  logic [TOTAL_W-1:0] out_tot_q, out_tot_d;
  logic [USED_W-1:0]  out_used_q, out_used_d;

  // RAM port signals.
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  entry_t             ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;
  entry_t             ram_rdata;

  // Decoding of the entry under check.
  logic [SIZE_W-1:0]  old_size;
  logic [SIZE_W-1:0]  new_size;
  entry_t             merged;
  entry_t             new_entry;
  logic               is_inside;
  logic               by_start;
  logic               by_end;
  logic               last_chk;
  logic               pick_hit;

  isip_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_RANGES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OUT_W'({out_used_q, out_tot_q, out_sts_q, out_val_q});

  // The three overlap tests are checked in order: containment first, then
  // growth at the front, then growth at the back.
  assign is_inside = (start_q >= ram_rdata.first) && (end_q <= ram_rdata.last);
  assign by_start  = (start_q < ram_rdata.first) && (end_q >= ram_rdata.first);
  assign by_end    = (start_q <= ram_rdata.last) && (end_q >= ram_rdata.last);
  assign last_chk  = (CNT_W'(chk_idx_q + CNT_W'(1)) == used_q);
  assign old_size  = range_size(ram_rdata);
  assign pick_hit  = ({1'b0, rem_q} < old_size);
  assign new_entry = '{last: end_q, first: start_q};

  // Entry after a merge. Growth at the front also takes the larger end.
  always_comb begin
    merged = ram_rdata;
    if (by_start) begin
      merged.first = start_q;
      if (end_q > ram_rdata.last) begin
        merged.last = end_q;
      end
    end else begin
      merged.last = end_q;
    end
  end

  assign new_size = range_size(merged);

  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    total_d     = total_q;
    act_d       = act_q;
    start_d     = start_q;
    end_d       = end_q;
    rem_d       = rem_q;
    rd_idx_d    = rd_idx_q;
    chk_d       = 1'b0;
    chk_idx_d   = chk_idx_q;
    pos_d       = pos_q;
    pos_found_d = pos_found_q;
    shr_idx_d   = shr_idx_q;
    pend_d      = pend_q;
    pend_addr_d = pend_addr_q;
    res_val_d   = res_val_q;
    res_sts_d   = res_sts_q;
    out_vld_d   = out_vld_q && !m_axis_tready;
    out_val_d   = out_val_q;
    out_sts_d   = out_sts_q;
    out_tot_d   = out_tot_q;
    out_used_d  = out_used_q;
    ram_we      = 1'b0;
    ram_waddr   = chk_idx_q[IDX_W-1:0];
    ram_wdata   = merged;
    ram_raddr   = rd_idx_q[IDX_W-1:0];

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          act_d       = s_axis_tdata[ACT_W-1:0];
          start_d     = s_axis_tdata[ACT_W +: VAL_W];
          end_d       = s_axis_tdata[ACT_W + VAL_W +: VAL_W];
          rem_d       = s_axis_tdata[ACT_W + 2 * VAL_W +: VAL_W];
          res_val_d   = '0;
          res_sts_d   = STS_OK;
          rd_idx_d    = '0;
          pos_d       = used_q;
          pos_found_d = 1'b0;
          shr_idx_d   = used_q;
          pend_d      = 1'b0;
          case (s_axis_tdata[ACT_W-1:0])
            ACT_INSERT: begin
              if (s_axis_tdata[ACT_W +: VAL_W] > s_axis_tdata[ACT_W + VAL_W +: VAL_W]) begin
                res_sts_d = STS_ORDER;
                state_d   = S_RESP;
              end else if (used_q == '0) begin
                state_d = S_SHIFT;
              end else begin
                state_d = S_SCAN;
              end
            end
            ACT_PICK: begin
              if (used_q == '0) begin
                res_sts_d = STS_RANGE;
                state_d   = S_RESP;
              end else begin
                state_d = S_SCAN;
              end
            end
            ACT_CLEAR: begin
              used_d  = '0;
              total_d = '0;
              state_d = S_RESP;
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end
      end

      S_SCAN: begin
        // Keep one read in flight so that one entry is checked per cycle.
        if (rd_idx_q < used_q) begin
          chk_d     = 1'b1;
          chk_idx_d = rd_idx_q;
          rd_idx_d  = CNT_W'(rd_idx_q + CNT_W'(1));
        end
        if (chk_q) begin
          if (act_q == ACT_PICK) begin
            if (pick_hit) begin
              res_val_d = ram_rdata.first + rem_q;
              state_d   = S_RESP;
            end else begin
              rem_d = rem_q - old_size[VAL_W-1:0];
              if (last_chk) begin
                res_sts_d = STS_RANGE;
                state_d   = S_RESP;
              end
            end
          end else if (is_inside) begin
            state_d = S_RESP;
          end else if (by_start || by_end) begin
            ram_we  = 1'b1;
            total_d = total_q + TOTAL_W'(new_size) - TOTAL_W'(old_size);
            state_d = S_RESP;
          end else begin
            if (!pos_found_q && (end_q < ram_rdata.first)) begin
              pos_d       = chk_idx_q;
              pos_found_d = 1'b1;
            end
            if (last_chk) begin
              if (used_q == CNT_W'(MAX_RANGES)) begin
                res_sts_d = STS_FULL;
                state_d   = S_RESP;
              end else begin
                state_d = S_SHIFT;
              end
            end
          end
        end
      end

      S_SHIFT: begin
        // Move entries up by one from the top down to the insertion point,
        // writing each entry that is read back one place higher.
        ram_raddr = IDX_W'(shr_idx_q - CNT_W'(1));
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = pend_addr_q[IDX_W-1:0];
          ram_wdata = ram_rdata;
        end
        if (shr_idx_q > pos_q) begin
          pend_d      = 1'b1;
          pend_addr_d = shr_idx_q;
          shr_idx_d   = CNT_W'(shr_idx_q - CNT_W'(1));
        end else if (!pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = pos_q[IDX_W-1:0];
          ram_wdata = new_entry;
          used_d    = CNT_W'(used_q + CNT_W'(1));
          total_d   = total_q + TOTAL_W'(range_size(new_entry));
          state_d   = S_RESP;
        end else begin
          pend_d = 1'b0;
        end
      end

      S_RESP: begin
        if (!out_vld_q || m_axis_tready) begin
          out_vld_d  = 1'b1;
          out_val_d  = res_val_q;
          out_sts_d  = res_sts_q;
          out_tot_d  = total_q;
          out_used_d = USED_W'(used_q);
          state_d    = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      used_q    <= '0;
      total_q   <= '0;
      chk_q     <= 1'b0;
      pend_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      used_q    <= used_d;
      total_q   <= total_d;
      chk_q     <= chk_d;
      pend_q    <= pend_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q       <= act_d;
    start_q     <= start_d;
    end_q       <= end_d;
    rem_q       <= rem_d;
    rd_idx_q    <= rd_idx_d;
    chk_idx_q   <= chk_idx_d;
    pos_q       <= pos_d;
    pos_found_q <= pos_found_d;
    shr_idx_q   <= shr_idx_d;
    pend_addr_q <= pend_addr_d;
    res_val_q   <= res_val_d;
    res_sts_q   <= res_sts_d;
    out_val_q   <= out_val_d;
    out_sts_q   <= out_sts_d;
    out_tot_q   <= out_tot_d;
    out_used_q  <= out_used_d;
  end

endmodule

// File: rtl/isip_ram.sv
// ============================================================================
// isip_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ============================================================================
module isip_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
